/* rtl/core/salru_pkg.sv */
// Shared constants and types for the set-associative LRU tag store.
`timescale 1ns / 1ps

package salru_pkg;

	localparam int MAX_SET_BITS = 6;
	localparam int MAX_WAYS     = 8;
	localparam int ADDR_BITS    = 64;

	localparam int NUM_SETS   = 1 << MAX_SET_BITS;
	localparam int OFFSET_MAX = ADDR_BITS - MAX_SET_BITS - 1;
	localparam int WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WAYS_W     = $clog2(MAX_WAYS + 1);
	localparam int RANK_W     = WAY_W;
	localparam int TAG_W      = ADDR_BITS - 1;
	localparam int SHIFT_W    = $clog2(ADDR_BITS);

	// configuration register widths and indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam int SETB_W     = 3;
	localparam int OFFB_W     = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE    = 2'd2;

	localparam logic [SETB_W-1:0] SETB_RESET = 3'd4;
	localparam logic [OFFB_W-1:0] OFFB_RESET = 6'd4;
	localparam logic [WAYS_W-1:0] WAYS_RESET = WAYS_W'(1);

	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

	// one classified access, passed from front to back
	typedef struct packed {
		logic [MAX_SET_BITS-1:0] set;
		logic [TAG_W-1:0]        tag;
		logic [WAYS_W-1:0]       ways;
	} item_t;

	// one set of the tag store: every way side by side
	typedef struct packed {
		logic [MAX_WAYS-1:0]              valid;
		logic [MAX_WAYS-1:0][RANK_W-1:0]  rank;
		logic [MAX_WAYS-1:0][TAG_W-1:0]   tag;
	} row_t;

endpackage

/* rtl/core/salru_front.sv */
// Front end: configuration registers, address split into set and tag, queue push.
`timescale 1ns / 1ps

module salru_front import salru_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [ADDR_BITS-1:0]  address,
	output logic                  busy,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  q_full,
	output logic                  push,
	output item_t                 push_item
);

	logic [SETB_W-1:0]       set_bits_q;
	logic [OFFB_W-1:0]       off_bits_q;
	logic [WAYS_W-1:0]       ways_q;
	logic [SETB_W-1:0]       s_c;
	logic [OFFB_W-1:0]       b_c;
	logic [WAYS_W-1:0]       n_c;
	logic [SHIFT_W-1:0]      sb_c;
	logic [ADDR_BITS-1:0]    addr_b_c;
	logic [MAX_SET_BITS-1:0] set_mask_c;

	assign cfg_ready = 1'b1;

	// configuration writes; unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= SETB_RESET;
			off_bits_q <= OFFB_RESET;
			ways_q     <= WAYS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SET_INDEX_BITS: set_bits_q <= cfg_data[SETB_W-1:0];
				CFG_OFFSET_BITS:    off_bits_q <= cfg_data[OFFB_W-1:0];
				CFG_WAYS_IN_USE:    ways_q     <= cfg_data[WAYS_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp register values at use
	always_comb begin
		if (set_bits_q == '0)
			s_c = SETB_W'(1);
		else if (set_bits_q > SETB_W'(MAX_SET_BITS))
			s_c = SETB_W'(MAX_SET_BITS);
		else
			s_c = set_bits_q;

		if (off_bits_q == '0)
			b_c = OFFB_W'(1);
		else if (off_bits_q > OFFB_W'(OFFSET_MAX))
			b_c = OFFB_W'(OFFSET_MAX);
		else
			b_c = off_bits_q;

		if (ways_q == '0)
			n_c = WAYS_W'(1);
		else if (ways_q > WAYS_W'(MAX_WAYS))
			n_c = WAYS_W'(MAX_WAYS);
		else
			n_c = ways_q;
	end

	// split the address
	assign sb_c       = SHIFT_W'(s_c) + SHIFT_W'(b_c);
	assign addr_b_c   = address >> b_c;
	assign set_mask_c = MAX_SET_BITS'((MAX_SET_BITS + 1)'(1) << s_c) - MAX_SET_BITS'(1);

	always_comb begin
		push_item.set  = addr_b_c[MAX_SET_BITS-1:0] & set_mask_c;
		push_item.tag  = TAG_W'(address >> sb_c);
		push_item.ways = n_c;
	end

	assign busy = q_full;
	assign push = start && !busy;

endmodule

/* rtl/core/salru_queue.sv */
// Two-entry queue that decouples the front end from the tag store.
`timescale 1ns / 1ps

module salru_queue import salru_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	output logic  empty,
	input  logic  pop,
	output item_t pop_item
);

	item_t       slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_item = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// payload slots
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_item;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("queue pop while empty");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 2'd1))
		else $error("queue count did not advance on push");
`endif

endmodule

/* rtl/core/salru_back.sv */
// Back end: set memory read, way compare, LRU update, write back and counters.
`timescale 1ns / 1ps

module salru_back import salru_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	output logic                    pop,
	input  item_t                   pop_item,
	output logic                    done,
	output logic                    hit,
	output logic                    miss,
	output logic                    eviction,
	output logic [MAX_SET_BITS-1:0] set_number,
	output logic [WAY_W-1:0]        way_used,
	output logic [31:0]             hit_total,
	output logic [31:0]             miss_total,
	output logic [31:0]             eviction_total
);

	row_t                    row_mem_q [NUM_SETS];
	logic [NUM_SETS-1:0]     row_init_q;

	// read stage
	logic                    vld_s1;
	item_t                   item_s1;
	row_t                    rd_row_s1;
	logic                    init_s1;
	logic                    byp_s1;
	row_t                    wr_row_q;

	// exec stage logic
	row_t                    row_c;
	row_t                    new_row_c;
	logic [MAX_WAYS-1:0]     in_use_c;
	logic                    hit_c;
	logic                    free_c;
	logic [WAY_W-1:0]        hit_way_c;
	logic [WAY_W-1:0]        free_way_c;
	logic [WAY_W-1:0]        lru_way_c;
	logic [WAY_W-1:0]        way_c;
	logic                    was_valid_c;
	logic [RANK_W-1:0]       old_rank_c;

	// result registers
	logic                    done_q;
	logic                    hit_q;
	logic                    miss_q;
	logic                    evict_q;
	logic [MAX_SET_BITS-1:0] set_q;
	logic [WAY_W-1:0]        way_q;
	logic [31:0]             hits_seen_q;
	logic [31:0]             misses_seen_q;
	logic [31:0]             evictions_seen_q;

	// the back never stalls: take a beat whenever one waits
	assign pop = !q_empty;

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			byp_s1 <= 1'b0;
		end else begin
			vld_s1 <= pop;
			byp_s1 <= pop && vld_s1 && (pop_item.set == item_s1.set);
		end
	end

	// set memory: one row read, one row written per cycle
	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1   <= pop_item;
			rd_row_s1 <= row_mem_q[pop_item.set];
			init_s1   <= row_init_q[pop_item.set];
		end
		if (vld_s1) begin
			row_mem_q[item_s1.set] <= new_row_c;
			wr_row_q               <= new_row_c;
		end
	end

	// rows never written read as all-invalid with zero ranks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			row_init_q <= '0;
		else if (vld_s1)
			row_init_q[item_s1.set] <= 1'b1;
	end

	// compare, pick the way, update ranks
	always_comb begin
		row_c = byp_s1 ? wr_row_q : (init_s1 ? rd_row_s1 : '0);
		hit_c      = 1'b0;
		free_c     = 1'b0;
		hit_way_c  = '0;
		free_way_c = '0;
		lru_way_c  = '0;
		for (int i = 0; i < MAX_WAYS; i++) begin
			in_use_c[i] = (WAYS_W'(i) < item_s1.ways);
		end
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (!hit_c && in_use_c[i] && row_c.valid[i] && (row_c.tag[i] == item_s1.tag)) begin
				hit_c     = 1'b1;
				hit_way_c = WAY_W'(i);
			end
			if (!free_c && in_use_c[i] && !row_c.valid[i]) begin
				free_c     = 1'b1;
				free_way_c = WAY_W'(i);
			end
		end
		// oldest rank, lowest way on ties
		for (int i = 1; i < MAX_WAYS; i++) begin
			if (in_use_c[i] && (row_c.rank[i] > row_c.rank[lru_way_c]))
				lru_way_c = WAY_W'(i);
		end
		if (hit_c)
			way_c = hit_way_c;
		else if (free_c)
			way_c = free_way_c;
		else
			way_c = lru_way_c;
		was_valid_c = hit_c || !free_c;
		old_rank_c  = row_c.rank[way_c];

		new_row_c = row_c;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (in_use_c[i] && row_c.valid[i] && (WAY_W'(i) != way_c) &&
			    (!was_valid_c || (row_c.rank[i] < old_rank_c)) &&
			    (row_c.rank[i] != RANK_MAX))
				new_row_c.rank[i] = row_c.rank[i] + RANK_W'(1);
		end
		new_row_c.rank[way_c] = '0;
		if (!hit_c) begin
			new_row_c.valid[way_c] = 1'b1;
			new_row_c.tag[way_c]   = item_s1.tag;
		end
	end

	// result beat and saturating counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q           <= 1'b0;
			hits_seen_q      <= '0;
			misses_seen_q    <= '0;
			evictions_seen_q <= '0;
		end else begin
			done_q <= vld_s1;
			if (vld_s1) begin
				if (hit_c && (hits_seen_q != '1))
					hits_seen_q <= hits_seen_q + 32'd1;
				if (!hit_c && (misses_seen_q != '1))
					misses_seen_q <= misses_seen_q + 32'd1;
				if (!hit_c && !free_c && (evictions_seen_q != '1))
					evictions_seen_q <= evictions_seen_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			hit_q   <= hit_c;
			miss_q  <= !hit_c;
			evict_q <= !hit_c && !free_c;
			set_q   <= item_s1.set;
			way_q   <= way_c;
		end
	end

	assign done           = done_q;
	assign hit            = hit_q;
	assign miss           = miss_q;
	assign eviction       = evict_q;
	assign set_number     = set_q;
	assign way_used       = way_q;
	assign hit_total      = hits_seen_q;
	assign miss_total     = misses_seen_q;
	assign eviction_total = evictions_seen_q;

`ifndef SYNTHESIS
	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (hit_q != miss_q)) else $error("hit and miss not exclusive");
	a_evict_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && evict_q) |-> miss_q) else $error("eviction without miss");
	a_row_marked: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> row_init_q[$past(item_s1.set)]) else $error("written row not marked");
	a_bypass_src: assert property (@(posedge clk) disable iff (!arst_n)
		byp_s1 |-> $past(vld_s1)) else $error("bypass without a preceding write");
	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && hit_q) |-> (hits_seen_q != 32'd0)) else $error("hit not counted");
`endif

endmodule

/* rtl/core/set_assoc_cache_lru_lookup_top.sv */
// An accepted beat passes the queue slot, read stage and result registers to its strobe.
// Throughput: one address per cycle; the set memory read and the same-cycle write
// back overlap through a one-row bypass. busy rises only when the two-entry queue is full.
// Reset: config returns to its reset values, counters clear, every set reads as empty
// at once through per-set valid flags; no clearing pass. The receiver cannot stall.
`timescale 1ns / 1ps

module set_assoc_cache_lru_lookup_top import salru_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [ADDR_BITS-1:0]    address,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output logic                    done,
	output logic                    hit,
	output logic                    miss,
	output logic                    eviction,
	output logic [MAX_SET_BITS-1:0] set_number,
	output logic [WAY_W-1:0]        way_used,
	output logic [31:0]             hit_total,
	output logic [31:0]             miss_total,
	output logic [31:0]             eviction_total
);

	logic  q_full;
	logic  q_empty;
	logic  push;
	logic  pop;
	item_t push_item;
	item_t pop_item;

	salru_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.address   (address),
		.busy      (busy),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	salru_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.empty     (q_empty),
		.pop       (pop),
		.pop_item  (pop_item)
	);

	salru_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.pop            (pop),
		.pop_item       (pop_item),
		.done           (done),
		.hit            (hit),
		.miss           (miss),
		.eviction       (eviction),
		.set_number     (set_number),
		.way_used       (way_used),
		.hit_total      (hit_total),
		.miss_total     (miss_total),
		.eviction_total (eviction_total)
	);

endmodule

/* dv/lru_lookup_checker.sv */
// Checker for the LRU tag store: mirrors its lines, predicts each lookup and compares results.
`timescale 1ns / 1ps

module lru_lookup_checker import salru_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic [ADDR_BITS-1:0]    address,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    done,
	input  logic                    hit,
	input  logic                    miss,
	input  logic                    eviction,
	input  logic [MAX_SET_BITS-1:0] set_number,
	input  logic [WAY_W-1:0]        way_used,
	input  logic [31:0]             hit_total,
	input  logic [31:0]             miss_total,
	input  logic [31:0]             eviction_total,
	output int                      outstanding,
	output int                      fail_count
);

	localparam int NUM_LINES  = NUM_SETS * MAX_WAYS;

	// one predicted lookup outcome
	typedef struct {
		logic                    hit;
		logic                    miss;
		logic                    eviction;
		logic [MAX_SET_BITS-1:0] set_number;
		logic [WAY_W-1:0]        way;
		logic [31:0]             hits;
		logic [31:0]             misses;
		logic [31:0]             evictions;
	} lookup_t;

	// shadow registers, as written
	logic [SETB_W-1:0]  set_bits_reg;
	logic [OFFB_W-1:0]  offset_bits_reg;
	logic [WAYS_W-1:0]  ways_reg;

	// mirrored tag store and counters
	bit                 line_valid [NUM_LINES];
	logic [TAG_W-1:0]   line_tag   [NUM_LINES];
	logic [RANK_W-1:0]  line_rank  [NUM_LINES];
	logic [31:0]        hits_seen;
	logic [31:0]        misses_seen;
	logic [31:0]        evictions_seen;

	lookup_t            lookups_due[$];

	initial fail_count = 0;

	function automatic int clamp_field(int v, int lo, int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	function automatic void clear_model();
		set_bits_reg    = SETB_RESET;
		offset_bits_reg = OFFB_RESET;
		ways_reg        = WAYS_RESET;
		for (int i = 0; i < NUM_LINES; i++) begin
			line_valid[i] = 1'b0;
			line_tag[i]   = '0;
			line_rank[i]  = '0;
		end
		hits_seen      = '0;
		misses_seen    = '0;
		evictions_seen = '0;
		lookups_due.delete();
	endfunction

	// make way w the most recent of the first n ways; newer valid lines age by one
	function automatic void bump_recency(int base, int n, int w, bit was_valid);
		logic [RANK_W-1:0] old_rank;
		old_rank = line_rank[base + w];
		for (int i = 0; i < n; i++) begin
			if (i != w && line_valid[base + i] && line_rank[base + i] != RANK_MAX &&
			    (!was_valid || line_rank[base + i] < old_rank))
				line_rank[base + i] = line_rank[base + i] + 1'b1;
		end
		line_rank[base + w] = '0;
	endfunction

	// split the address, search the set, fill or replace, queue the outcome
	function automatic void predict_lookup(input logic [ADDR_BITS-1:0] addr);
		int                      s;
		int                      b;
		int                      n;
		int                      base;
		int                      way;
		logic [ADDR_BITS-1:0]    upper;
		logic [TAG_W-1:0]        tg;
		logic [MAX_SET_BITS-1:0] st;
		bit                      found;
		bit                      free_way;
		bit                      evict;
		lookup_t                 r;
		s     = clamp_field(int'(set_bits_reg), 1, MAX_SET_BITS);
		b     = clamp_field(int'(offset_bits_reg), 1, OFFSET_MAX);
		n     = clamp_field(int'(ways_reg), 1, MAX_WAYS);
		upper = addr >> (s + b);
		tg    = upper[TAG_W-1:0];
		st    = MAX_SET_BITS'((addr >> b) & ((ADDR_BITS'(1) << s) - ADDR_BITS'(1)));
		base  = int'(st) * MAX_WAYS;
		found    = 1'b0;
		free_way = 1'b0;
		evict    = 1'b0;
		way      = 0;
		// lowest matching way wins when a tag sits in several ways
		for (int i = 0; i < n; i++) begin
			if (!found && line_valid[base + i] && line_tag[base + i] == tg) begin
				found = 1'b1;
				way   = i;
			end
		end
		if (found) begin
			if (hits_seen != '1) hits_seen = hits_seen + 32'd1;
			bump_recency(base, n, way, 1'b1);
		end else begin
			if (misses_seen != '1) misses_seen = misses_seen + 32'd1;
			for (int i = 0; i < n; i++) begin
				if (!free_way && !line_valid[base + i]) begin
					free_way = 1'b1;
					way      = i;
				end
			end
			// no free way: oldest rank goes, lowest way on a tie
			if (!free_way) begin
				evict = 1'b1;
				if (evictions_seen != '1) evictions_seen = evictions_seen + 32'd1;
				for (int i = 1; i < n; i++)
					if (line_rank[base + i] > line_rank[base + way]) way = i;
			end
			bump_recency(base, n, way, !free_way);
			line_valid[base + way] = 1'b1;
			line_tag[base + way]   = tg;
		end
		r.hit        = found;
		r.miss       = !found;
		r.eviction   = evict;
		r.set_number = st;
		r.way        = WAY_W'(way);
		r.hits       = hits_seen;
		r.misses     = misses_seen;
		r.evictions  = evictions_seen;
		lookups_due.push_back(r);
	endfunction

	// report and count one mismatch
	function automatic void note_mismatch(string field, logic [63:0] want, logic [63:0] got);
		fail_count++;
		$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
	endfunction

	function automatic void check_lookup();
		lookup_t want;
		if (lookups_due.size() == 0) begin
			fail_count++;
			$display("%0t: result beat with no lookup pending, set %0h way %0h",
			         $time, set_number, way_used);
			return;
		end
		want = lookups_due.pop_front();
		if (hit !== want.hit)                 note_mismatch("hit", want.hit, hit);
		if (miss !== want.miss)               note_mismatch("miss", want.miss, miss);
		if (eviction !== want.eviction)       note_mismatch("eviction", want.eviction, eviction);
		if (set_number !== want.set_number)   note_mismatch("set_number", want.set_number, set_number);
		if (way_used !== want.way)            note_mismatch("way_used", want.way, way_used);
		if (hit_total !== want.hits)          note_mismatch("hit_total", want.hits, hit_total);
		if (miss_total !== want.misses)       note_mismatch("miss_total", want.misses, miss_total);
		if (eviction_total !== want.evictions)
			note_mismatch("eviction_total", want.evictions, eviction_total);
	endfunction

	// results first, then register writes, then the new access beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
			outstanding <= 0;
		end else begin
			if (done) check_lookup();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SET_INDEX_BITS: set_bits_reg    = cfg_data[SETB_W-1:0];
					CFG_OFFSET_BITS:    offset_bits_reg = cfg_data[OFFB_W-1:0];
					CFG_WAYS_IN_USE:    ways_reg        = cfg_data[WAYS_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) predict_lookup(address);
			outstanding <= lookups_due.size();
		end
	end

endmodule

/* dv/set_assoc_cache_lru_lookup_top_test.sv */
// Testbench top for the LRU tag store: clock, reset, access and register stimulus, verdict.
`timescale 1ns / 1ps

module set_assoc_cache_lru_lookup_top_test;
	import salru_pkg::*;

	localparam int TOTAL_ACCESSES = 1250;
	localparam int CYCLE_LIMIT    = 200000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    start     = 1'b0;
	logic [ADDR_BITS-1:0]    address   = '0;
	logic                    cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data  = '0;
	logic                    busy;
	logic                    cfg_ready;
	logic                    done;
	logic                    hit;
	logic                    miss;
	logic                    eviction;
	logic [MAX_SET_BITS-1:0] set_number;
	logic [WAY_W-1:0]        way_used;
	logic [31:0]             hit_total;
	logic [31:0]             miss_total;
	logic [31:0]             eviction_total;
	int                      outstanding;
	int                      fail_count;
	int unsigned             cycle_count = 0;

	// current address split as the stimulus sees it, used only to aim addresses
	int                      eff_set_bits    = 4;
	int                      eff_offset_bits = 4;
	int                      eff_ways        = 1;
	logic [ADDR_BITS-1:0]    tag_pool [12];
	logic [MAX_SET_BITS-1:0] set_pool [3];
	int                      tag_count = 1;
	int                      set_count = 1;
	bit                      no_idle   = 1'b0;
	int                      sent      = 0;

	set_assoc_cache_lru_lookup_top u_top (.*);

	lru_lookup_checker u_checker (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("set_assoc_cache_lru_lookup_top_test: errors");
			$finish;
		end
	end

	function automatic int clamp_int(int v, int lo, int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	// mostly working-set addresses; some fresh tags and some fully random noise
	function automatic logic [ADDR_BITS-1:0] next_addr();
		logic [ADDR_BITS-1:0] tg;
		logic [ADDR_BITS-1:0] set_field;
		logic [ADDR_BITS-1:0] offset_mask;
		int                   pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) return {$urandom, $urandom};
		tg = (pick < 20) ? {$urandom, $urandom} : tag_pool[$urandom_range(0, tag_count - 1)];
		set_field = ADDR_BITS'(set_pool[$urandom_range(0, set_count - 1)]) &
		            ((ADDR_BITS'(1) << eff_set_bits) - ADDR_BITS'(1));
		offset_mask = (ADDR_BITS'(1) << eff_offset_bits) - ADDR_BITS'(1);
		return (tg << (eff_set_bits + eff_offset_bits)) | (set_field << eff_offset_bits) |
		       ({$urandom, $urandom} & offset_mask);
	endfunction

	// one access beat; start stays high across back-to-back beats
	task automatic send_access(input logic [ADDR_BITS-1:0] addr);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			start   <= 1'b0;
			address <= {$urandom, $urandom};
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		address <= addr;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	// caller drops cfg_valid after its last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// hold off until every result is back, then let the pipeline settle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic reconfigure(input logic [CFG_DATA_W-1:0] s, input logic [CFG_DATA_W-1:0] o,
	                           input logic [CFG_DATA_W-1:0] w, input bit stray_write);
		drain();
		if (stray_write) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
		write_reg(CFG_SET_INDEX_BITS, s);
		write_reg(CFG_OFFSET_BITS, o);
		write_reg(CFG_WAYS_IN_USE, w);
		cfg_valid <= 1'b0;
		eff_set_bits    = clamp_int(int'(s[SETB_W-1:0]), 1, MAX_SET_BITS);
		eff_offset_bits = clamp_int(int'(o[OFFB_W-1:0]), 1, OFFSET_MAX);
		eff_ways        = clamp_int(int'(w[WAYS_W-1:0]), 1, MAX_WAYS);
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] s_val;
		logic [CFG_DATA_W-1:0] o_val;
		logic [CFG_DATA_W-1:0] w_val;
		int                    phase_len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset split, one way: fill, hit, top set, then evictions
		send_access('0);
		send_access('0);
		send_access('1);
		send_access(64'h100);
		send_access('0);

		// widest split: one tag bit, all sets, all ways
		reconfigure(6'd6, 6'd57, 6'd8, 1'b0);
		send_access('0);
		send_access(64'h8000_0000_0000_0000);
		send_access('1);
		send_access(64'h7FFF_FFFF_FFFF_FFFF);
		send_access('0);

		// narrowest split, two ways: tags 1 and 2 in set 0
		reconfigure(6'd1, 6'd1, 6'd2, 1'b0);
		send_access(64'h4);
		send_access(64'h8);

		// one way: tag 2 replaces way 0, leaving the same tag in both ways
		reconfigure(6'd1, 6'd1, 6'd1, 1'b0);
		send_access(64'h8);

		// two ways again: lowest matching way hits, tied ranks evict the lower way
		reconfigure(6'd1, 6'd1, 6'd2, 1'b0);
		send_access(64'h8);
		send_access(64'hC);
		send_access(64'h4);

		// zero register values clamp up; a write to the unused index is dropped
		reconfigure(6'd0, 6'd0, 6'd0, 1'b1);
		send_access('0);
		send_access(64'h2);
		send_access(64'h6);

		// all-ones register values clamp down
		reconfigure(6'h3F, 6'h3F, 6'h3F, 1'b1);
		send_access('1);
		send_access('0);
		send_access({$urandom, $urandom});

		// random phases: new split, new working set, idle pattern per phase
		while (sent < TOTAL_ACCESSES) begin
			s_val = CFG_DATA_W'($urandom);
			case ($urandom_range(0, 3))
				0: o_val = CFG_DATA_W'($urandom);
				1: o_val = CFG_DATA_W'($urandom_range(50, 63));
				default: o_val = CFG_DATA_W'($urandom_range(0, 12));
			endcase
			w_val = CFG_DATA_W'($urandom);
			reconfigure(s_val, o_val, w_val, $urandom_range(0, 3) == 0);
			// as many tags as ways or up to three more, over one to three sets, to force replacement
			tag_count = eff_ways + $urandom_range(0, 3);
			set_count = $urandom_range(1, 3);
			foreach (tag_pool[i]) tag_pool[i] = {$urandom, $urandom};
			foreach (set_pool[i]) set_pool[i] = MAX_SET_BITS'($urandom);
			no_idle   = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(40, 120);
			repeat (phase_len) send_access(next_addr());
		end

		drain();
		if (fail_count == 0) begin
			$display("set_assoc_cache_lru_lookup_top_test: clean");
		end else begin
			$display("set_assoc_cache_lru_lookup_top_test: errors");
		end
		$finish;
	end

endmodule
